@@ sv/harf_pkg.sv @@
// Shared types, constants and helper functions for the ASCII request framer.
// Used by harf_front, harf_queue, harf_back and hvac_ascii_request_framer.
// No dependencies.
package harf_pkg;

    // Default limit on payload bytes shown as hex digits in one write frame.
    localparam int MAX_HEX_BYTES_DEF = 32;
    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [15:0] SUM_INIT = 16'hFFFF;

    // Character positions within the common frame layout.
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_HEAD      = 5'd0;
    localparam logic [POS_W-1:0] POS_T         = 5'd1;
    localparam logic [POS_W-1:0] POS_SP0       = 5'd2;
    localparam logic [POS_W-1:0] POS_P         = 5'd3;
    localparam logic [POS_W-1:0] POS_EQ0       = 5'd4;
    localparam logic [POS_W-1:0] POS_ADDR3     = 5'd5;
    localparam logic [POS_W-1:0] POS_ADDR2     = 5'd6;
    localparam logic [POS_W-1:0] POS_ADDR1     = 5'd7;
    localparam logic [POS_W-1:0] POS_ADDR0     = 5'd8;
    localparam logic [POS_W-1:0] POS_COMMA     = 5'd9;
    localparam logic [POS_W-1:0] POS_HEX_HI    = 5'd10;
    localparam logic [POS_W-1:0] POS_HEX_LO    = 5'd11;
    localparam logic [POS_W-1:0] POS_SP1       = 5'd12;
    localparam logic [POS_W-1:0] POS_C         = 5'd13;
    localparam logic [POS_W-1:0] POS_EQ1       = 5'd14;
    localparam logic [POS_W-1:0] POS_SUM3      = 5'd15;
    localparam logic [POS_W-1:0] POS_SUM2      = 5'd16;
    localparam logic [POS_W-1:0] POS_SUM1      = 5'd17;
    localparam logic [POS_W-1:0] POS_SUM0      = 5'd18;
    localparam logic [POS_W-1:0] POS_CR        = 5'd19;

    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // One queued command: the pieces of a frame that a single word produces.
    typedef struct packed {
        logic        has_head;
        logic        is_read;
        logic [15:0] addr;
        logic        has_hex;
        logic [7:0]  data;
        logic        has_tail;
        logic [15:0] sum;
    } cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_char = wide + 8'h30;
        end else begin
            hex_char = wide + 8'h37;
        end
    endfunction

    // 0xFFFF minus both address bytes.
    function automatic logic [15:0] addr_sum(input logic [15:0] a);
        addr_sum = SUM_INIT - {8'h00, a[15:8]} - {8'h00, a[7:0]};
    endfunction

endpackage

@@ sv/harf_front.sv @@
// Front end of the framer: accepts input words, keeps the open-frame state
// and turns each word into at most one command for the back end. Uses harf_pkg.
module harf_front
    import harf_pkg::*;
#(
    parameter int MAX_HEX_BYTES = MAX_HEX_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    input  logic        q_full,
    output logic        push,
    output cmd_t        push_cmd
);

    localparam int CNT_W = $clog2(MAX_HEX_BYTES + 1);

    logic [15:0]      sum_reg,   sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             open_reg,  open_next;

    logic             accept;
    logic             opening;
    logic [15:0]      base_sum;
    logic [15:0]      new_sum;
    logic [CNT_W-1:0] base_count;
    logic             emit_hex;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        opening    = s_first_byte || !open_reg;
        base_sum   = opening ? addr_sum(s_address) : sum_reg;
        base_count = opening ? '0 : count_reg;
        new_sum    = base_sum - {8'h00, s_data_byte};
        emit_hex   = base_count < CNT_W'(MAX_HEX_BYTES);

        push_cmd.addr = s_address;
        push_cmd.data = s_data_byte;
        if (!s_req_type) begin
            push_cmd.has_head = 1'b1;
            push_cmd.is_read  = 1'b1;
            push_cmd.has_hex  = 1'b0;
            push_cmd.has_tail = 1'b1;
            push_cmd.sum      = addr_sum(s_address);
        end else begin
            push_cmd.has_head = opening;
            push_cmd.is_read  = 1'b0;
            push_cmd.has_hex  = emit_hex;
            push_cmd.has_tail = s_last_byte;
            push_cmd.sum      = new_sum;
        end
        // A byte past the hex limit in the middle of a frame only updates the sum.
        push = accept && (push_cmd.has_head || push_cmd.has_hex || push_cmd.has_tail);

        sum_next   = sum_reg;
        count_next = count_reg;
        open_next  = open_reg;
        if (accept) begin
            if (!s_req_type || s_last_byte) begin
                sum_next   = SUM_INIT;
                count_next = '0;
                open_next  = 1'b0;
            end else begin
                sum_next   = new_sum;
                count_next = emit_hex ? base_count + CNT_W'(1) : base_count;
                open_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= SUM_INIT;
            count_reg <= '0;
            open_reg  <= 1'b0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

endmodule

@@ sv/harf_queue.sv @@
// Small command queue in flip-flops between the framer's front and back.
// Uses harf_pkg for the command type.
module harf_queue
    import harf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("command queue written while full");

endmodule

@@ sv/harf_back.sv @@
// Back end of the framer: walks the character positions of the command at
// the queue head and feeds a registered output stage. Uses harf_pkg.
module harf_back
    import harf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_frame_end
);

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic             busy_reg,  busy_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg,  char_next;
    logic             end_reg,   end_next;

    logic             load;
    logic [POS_W-1:0] cur_pos;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] step_pos;
    logic             done;
    logic [7:0]       cur_char;

    assign m_valid     = valid_reg;
    assign m_out_char  = char_reg;
    assign m_frame_end = end_reg;

    always_comb begin
        if (head_cmd.has_head) begin
            start_pos = POS_HEAD;
        end else if (head_cmd.has_hex) begin
            start_pos = POS_HEX_HI;
        end else begin
            start_pos = POS_SP1;
        end
        cur_pos = busy_reg ? pos_reg : start_pos;

        // Skip the comma on reads, the hex pair when the byte is past the
        // limit and the tail when the frame stays open.
        done     = 1'b0;
        step_pos = cur_pos + POS_W'(1);
        priority if (cur_pos == POS_ADDR0 && head_cmd.is_read) begin
            step_pos = POS_SP1;
        end else if (cur_pos == POS_COMMA && !head_cmd.has_hex) begin
            step_pos = POS_SP1;
            done     = !head_cmd.has_tail;
        end else if (cur_pos == POS_HEX_LO) begin
            done     = !head_cmd.has_tail;
        end else if (cur_pos == POS_CR) begin
            done     = 1'b1;
        end else begin
            done     = 1'b0;
        end

        unique case (cur_pos)
            POS_HEAD:   cur_char = head_cmd.is_read ? CHAR_M : CHAR_S;
            POS_T:      cur_char = CHAR_T;
            POS_SP0:    cur_char = CHAR_SPACE;
            POS_P:      cur_char = CHAR_P;
            POS_EQ0:    cur_char = CHAR_EQ;
            POS_ADDR3:  cur_char = hex_char(head_cmd.addr[15:12]);
            POS_ADDR2:  cur_char = hex_char(head_cmd.addr[11:8]);
            POS_ADDR1:  cur_char = hex_char(head_cmd.addr[7:4]);
            POS_ADDR0:  cur_char = hex_char(head_cmd.addr[3:0]);
            POS_COMMA:  cur_char = CHAR_COMMA;
            POS_HEX_HI: cur_char = hex_char(head_cmd.data[7:4]);
            POS_HEX_LO: cur_char = hex_char(head_cmd.data[3:0]);
            POS_SP1:    cur_char = CHAR_SPACE;
            POS_C:      cur_char = CHAR_C;
            POS_EQ1:    cur_char = CHAR_EQ;
            POS_SUM3:   cur_char = hex_char(head_cmd.sum[15:12]);
            POS_SUM2:   cur_char = hex_char(head_cmd.sum[11:8]);
            POS_SUM1:   cur_char = hex_char(head_cmd.sum[7:4]);
            POS_SUM0:   cur_char = hex_char(head_cmd.sum[3:0]);
            POS_CR:     cur_char = CHAR_CR;
            default:    cur_char = CHAR_SPACE;
        endcase

        load = head_valid && (!valid_reg || m_ready);
        pop  = load && done;

        pos_next   = pos_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        end_next   = end_reg;
        if (load) begin
            pos_next   = step_pos;
            busy_next  = !done;
            valid_next = 1'b1;
            char_next  = cur_char;
            end_next   = cur_pos == POS_CR;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_HEAD;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        end_reg  <= end_next;
    end

    a_busy_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> head_valid)
        else $error("sequencer mid-frame with no command at queue head");

    a_end_is_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && end_reg) |-> (char_reg == CHAR_CR))
        else $error("frame end flagged on a character other than CR");

    a_pop_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && cur_pos == POS_CR) |-> pop)
        else $error("command kept after its closing CR");

endmodule

@@ sv/hvac_ascii_request_framer.sv @@
// Top level of the ASCII request framer: front end, command queue and
// character back end. Depends on harf_pkg, harf_front, harf_queue, harf_back.
//
//   Channel   Ports                                   Direction  Word
//   input     s_valid s_ready s_req_type s_address    in         one request word
//             s_data_byte s_first_byte s_last_byte
//   result    m_valid m_ready m_out_char m_frame_end  out        one frame character
//
// The block emits one character per cycle while the receiver takes them; the
// back-end sequencer that walks a frame position by position sets the pace.
// A middle payload byte emits its hex pair, a frame's opening byte the head as
// well (and the tail when it also closes the frame), a read its head, address
// and tail; a byte past the hex limit emits none, or only the tail when it
// closes the frame. The front accepts one word per cycle while the queue has room.
// Reset (aresetn low at a clock edge) empties the queue, drops any partly
// emitted frame and closes the open write frame.
// A stalled receiver holds the output register; the queue then fills and
// s_ready falls only when all entries are taken.
module hvac_ascii_request_framer
    import harf_pkg::*;
#(
    parameter int MAX_HEX_BYTES = MAX_HEX_BYTES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_frame_end
);

    // Commands flow from the front to the back through the queue; each one
    // describes the head, hex pair and tail that a single word contributes.
    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head_cmd;

    harf_front #(
        .MAX_HEX_BYTES(MAX_HEX_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_address    (s_address),
        .s_data_byte  (s_data_byte),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .q_full       (q_full),
        .push         (q_push),
        .push_cmd     (q_push_cmd)
    );

    harf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // The back end owns the output register, so a waiting character blocks the
    // front from taking the next word only once the queue is full.
    harf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_head_valid),
        .head_cmd    (q_head_cmd),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_frame_end (m_frame_end)
    );

endmodule
